### rtl/diff_drive_odometry_core_assert.svh
// Assertion macros for the odometry core checker.
`ifndef DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH
`define DIFF_DRIVE_ODOMETRY_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define DDO_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("odometry core check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define DDO_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("odometry core check failed");

`endif

### rtl/ddo_pkg.sv
// Types, constants and helpers of the differential-drive odometry core.
package ddo_pkg;

    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 16;
    localparam int Q_SHIFT      = 16;
    localparam int CORDIC_STEPS = 24;

    // serial multiplier: signed a, unsigned b, one bit of b per cycle
    localparam int MA_W   = 43;
    localparam int MB_W   = 30;
    localparam int MP_W   = MA_W + MB_W;
    localparam int MH_W   = MA_W + 2;
    localparam int MCNT_W = $clog2(MB_W);

    // serial divide by one million, one quotient bit per cycle
    localparam int DV_W      = 53;
    localparam int DIV_STEPS = 33;
    localparam int DQ_W      = DIV_STEPS + 1;
    localparam int DIV_REM_W = 20;
    localparam int DCNT_W    = $clog2(DIV_STEPS);
    localparam logic [DIV_REM_W:0] DIVISOR = 21'd1000000;

    // CORDIC datapath
    localparam int CW   = FRAC_BITS + 3;
    localparam int ZW   = 34;
    localparam int CI_W = $clog2(CORDIC_STEPS);
    localparam logic [63:0] CORDIC_X0_64 =
        ((64'd2608131496 << FRAC_BITS) + 64'h0000_0000_8000_0000) >> 32;
    localparam logic [CW-1:0] CORDIC_X0 = CORDIC_X0_64[CW-1:0];
    localparam logic [31:0] ATAN_TURNS [0:CORDIC_STEPS-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // 1/(2*pi) in Q32, and where turn and half turn sit in the product
    localparam logic [MB_W-1:0] INV_TWO_PI_Q32 = 30'd683565276;
    localparam int D_LSB = 48 - ANGLE_BITS;
    localparam int H_LSB = 49 - ANGLE_BITS;

    localparam int INC_W = 48;

    // configuration register indexes
    localparam logic [1:0] REG_WHEEL_RADIUS     = 2'd0;
    localparam logic [1:0] REG_INV_WHEEL_RADIUS = 2'd1;
    localparam logic [1:0] REG_HALF_WHEEL_BASE  = 2'd2;
    localparam logic [1:0] REG_INV_WHEEL_BASE   = 2'd3;

    typedef struct packed {
        logic signed [23:0] linear_velocity;
        logic signed [23:0] angular_velocity;
        logic [19:0]        elapsed_time;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [15:0] heading;
        logic signed [31:0] left_wheel_angle;
        logic signed [31:0] right_wheel_angle;
    } t_out_word;

    typedef struct packed {
        logic                   start;
        logic signed [MA_W-1:0] a;
        logic [MB_W-1:0]        b;
    } t_mul_req;

    typedef struct packed {
        logic                   done;
        logic signed [MP_W-1:0] prod;
    } t_mul_rsp;

    typedef struct packed {
        logic                   start;
        logic signed [DV_W-1:0] dividend;
    } t_div_req;

    typedef struct packed {
        logic                   done;
        logic signed [DQ_W-1:0] quot;
    } t_div_rsp;

    typedef struct packed {
        logic                  start;
        logic [ANGLE_BITS-1:0] phi;
    } t_cor_req;

    typedef struct packed {
        logic                 done;
        logic signed [CW-1:0] cos_val;
        logic signed [CW-1:0] sin_val;
    } t_cor_rsp;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [INC_W-1:0] d);
        logic signed [INC_W:0] s;
        s = (INC_W+1)'(a) + (INC_W+1)'(d);
        if (s > (INC_W+1)'(64'sd2147483647)) begin
            return 32'sh7FFF_FFFF;
        end else if (s < (INC_W+1)'(-64'sd2147483648)) begin
            return 32'sh8000_0000;
        end
        return s[31:0];
    endfunction

endpackage

### rtl/ddo_mul.sv
// Bit-serial signed-by-unsigned multiplier, one bit of b per cycle.
module ddo_mul (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddo_pkg::t_mul_req i_req,
    output ddo_pkg::t_mul_rsp o_rsp
);
    import ddo_pkg::*;

    logic signed [MH_W-1:0] r_hi;
    logic [MB_W-1:0]        r_lo;
    logic [MB_W-1:0]        r_b;
    logic signed [MA_W-1:0] r_a;
    logic [MCNT_W-1:0]      r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic                   load;
    logic signed [MH_W-1:0] a_ext;
    logic signed [MH_W-1:0] sum;
    logic [MH_W+MB_W-1:0]   full;

    assign load  = i_req.start && !r_busy;
    assign a_ext = MH_W'(r_a);
    assign sum   = r_b[0] ? r_hi + a_ext : r_hi;
    assign full  = {r_hi, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= MCNT_W'(MB_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // partial product shifts right; low bits fall into r_lo
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_hi <= '0;
            r_lo <= '0;
            r_a  <= i_req.a;
            r_b  <= i_req.b;
        end else if (r_busy) begin
            r_hi <= sum >>> 1;
            r_lo <= {sum[0], r_lo[MB_W-1:1]};
            r_b  <= r_b >> 1;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.prod = $signed(full[MP_W-1:0]);

endmodule

### rtl/ddo_div.sv
// Serial divide by one million, truncating toward zero, one bit per cycle.
module ddo_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddo_pkg::t_div_req i_req,
    output ddo_pkg::t_div_rsp o_rsp
);
    import ddo_pkg::*;

    logic [DIV_REM_W-1:0] r_rem;
    logic [DIV_STEPS-1:0] r_lo;
    logic                 r_neg;
    logic [DCNT_W-1:0]    r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic                 load;
    logic [DV_W-1:0]      mag;
    logic [DIV_REM_W:0]   trial;
    logic [DIV_REM_W:0]   diff;
    logic                 ge;
    logic [DQ_W-1:0]      qext;

    assign load  = i_req.start && !r_busy;
    assign mag   = i_req.dividend[DV_W-1] ? DV_W'(-i_req.dividend) : i_req.dividend;
    assign trial = {r_rem, r_lo[DIV_STEPS-1]};
    assign diff  = trial - DIVISOR;
    assign ge    = trial >= DIVISOR;
    assign qext  = {1'b0, r_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_busy <= 1'b1;
                r_cnt  <= DCNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // top bits start below the divisor, so the quotient fits DIV_STEPS bits
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rem <= DIV_REM_W'(mag[DV_W-2:DIV_STEPS]);
            r_lo  <= mag[DIV_STEPS-1:0];
            r_neg <= i_req.dividend[DV_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_REM_W-1:0] : trial[DIV_REM_W-1:0];
            r_lo  <= {r_lo[DIV_STEPS-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_neg ? $signed(-qext) : $signed(qext);

endmodule

### rtl/ddo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, with quarter-turn fold.
module ddo_cordic (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ddo_pkg::t_cor_req i_req,
    output ddo_pkg::t_cor_rsp o_rsp
);
    import ddo_pkg::*;

    localparam logic signed [ZW-1:0] Z_QUARTER = ZW'(64'sd1073741824);
    localparam logic signed [ZW-1:0] Z_HALF    = ZW'(64'sd2147483648);

    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [ZW-1:0] r_z;
    logic [CI_W-1:0]      r_i;
    logic                 r_neg;
    logic                 r_busy;
    logic                 r_done;
    logic                 load;
    logic [31:0]          z32;
    logic signed [ZW-1:0] z_ext;
    logic signed [ZW-1:0] z_fold;
    logic                 fold;
    logic signed [CW-1:0] x_sh;
    logic signed [CW-1:0] y_sh;
    logic signed [ZW-1:0] atan_ext;

    assign load = i_req.start && !r_busy;
    assign z32  = {i_req.phi, {(32 - ANGLE_BITS){1'b0}}};
    assign z_ext = ZW'($signed(z32));

    always_comb begin
        fold   = 1'b0;
        z_fold = z_ext;
        if (z_ext > Z_QUARTER) begin
            fold   = 1'b1;
            z_fold = z_ext - Z_HALF;
        end else if (z_ext < -Z_QUARTER) begin
            fold   = 1'b1;
            z_fold = z_ext + Z_HALF;
        end
    end

    assign x_sh     = r_x >>> r_i;
    assign y_sh     = r_y >>> r_i;
    assign atan_ext = $signed(ZW'(ATAN_TURNS[r_i]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else begin
            r_done <= 1'b0;
            if (load) begin
                r_busy <= 1'b1;
                r_i    <= '0;
            end else if (r_busy) begin
                if (r_i == CI_W'(CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_i <= r_i + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_x   <= $signed(CORDIC_X0);
            r_y   <= '0;
            r_z   <= z_fold;
            r_neg <= fold;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - y_sh;
                r_y <= r_y + x_sh;
                r_z <= r_z - atan_ext;
            end else begin
                r_x <= r_x + y_sh;
                r_y <= r_y - x_sh;
                r_z <= r_z + atan_ext;
            end
        end
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.cos_val = r_neg ? -r_x : r_x;
    assign o_rsp.sin_val = r_neg ? -r_y : r_y;

endmodule

### rtl/diff_drive_odometry_core.sv
// Top level of the differential-drive odometry core: sequencer, state and ports.
//
//   channel   direction  handshake                      word
//   in        to core    i_in_valid / o_in_stall        t_in_word (v, w, dt)
//   out       from core  o_out_valid / i_out_stall      t_out_word (pose, wheels)
//   cfg       to core    i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
// A tick with nonzero elapsed time holds the input stalled from its accept until
// the core is free again: thirteen passes of the 30-bit serial multiplier, four
// passes of the serial divide by one million, 24 CORDIC rotations and then the
// result step. A zero-time tick is taken and dropped and leaves the core free.
// Reset is synchronous, active low, and restores the pose, wheel angles and
// registers. The result word sits in an output register, so a stalled consumer
// only holds the core at the final step.
module diff_drive_odometry_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ddo_pkg::t_in_word  i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ddo_pkg::t_out_word o_out_word,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import ddo_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_MUL_GO   = 3'd1;
    localparam logic [2:0] ST_MUL_WAIT = 3'd2;
    localparam logic [2:0] ST_DIV_WAIT = 3'd3;
    localparam logic [2:0] ST_COR_WAIT = 3'd4;
    localparam logic [2:0] ST_OUT      = 3'd5;

    // multiply steps, in order
    localparam logic [3:0] OP_T   = 4'd0;  // w * half base
    localparam logic [3:0] OP_QL  = 4'd1;  // left rate
    localparam logic [3:0] OP_QR  = 4'd2;  // right rate
    localparam logic [3:0] OP_AL  = 4'd3;  // left angle step, then divide
    localparam logic [3:0] OP_AR  = 4'd4;
    localparam logic [3:0] OP_WL  = 4'd5;  // left rate * radius
    localparam logic [3:0] OP_DL  = 4'd6;  // left arc, then divide
    localparam logic [3:0] OP_WR  = 4'd7;
    localparam logic [3:0] OP_DR  = 4'd8;
    localparam logic [3:0] OP_TH  = 4'd9;  // turn in radians
    localparam logic [3:0] OP_ANG = 4'd10; // turn in binary angle
    localparam logic [3:0] OP_X   = 4'd11;
    localparam logic [3:0] OP_Y   = 4'd12;

    logic [2:0] r_state;
    logic [3:0] r_op;

    // configuration
    logic [15:0] r_wr;
    logic [23:0] r_iwr;
    logic [15:0] r_hwb;
    logic [23:0] r_iwb;

    // pose and wheel state
    logic signed [31:0]     r_x;
    logic signed [31:0]     r_y;
    logic [ANGLE_BITS-1:0]  r_hd;
    logic signed [31:0]     r_left;
    logic signed [31:0]     r_right;

    // per-tick work registers
    logic signed [23:0]     r_v;
    logic signed [23:0]     r_w;
    logic [19:0]            r_dt;
    logic signed [23:0]     r_t;
    logic signed [32:0]     r_ql;
    logic signed [32:0]     r_qr;
    logic signed [32:0]     r_wl;
    logic signed [33:0]     r_dl;
    logic signed [33:0]     r_dr;
    logic signed [42:0]     r_dth;
    logic [ANGLE_BITS-1:0]  r_d;
    logic signed [CW-1:0]   r_c;
    logic signed [CW-1:0]   r_s;

    logic      r_out_valid;
    t_out_word r_out_word;

    t_mul_req mul_req;
    t_mul_rsp mul_rsp;
    t_div_req div_req;
    t_div_rsp div_rsp;
    t_cor_req cor_req;
    t_cor_rsp cor_rsp;

    logic acc_in;
    logic start_work;
    logic mul_fin;
    logic div_fin;
    logic cor_fin;
    logic out_load;
    logic is_div_op;

    logic signed [24:0]       vl;
    logic signed [24:0]       vr;
    logic signed [34:0]       dsum;
    logic signed [33:0]       ds;
    logic signed [34:0]       ddiff;
    logic [CW-1:0]            c_mag;
    logic [CW-1:0]            s_mag;
    logic signed [MP_W-1:0]   m_prod;
    logic signed [MP_W-1:0]   m_q;
    logic signed [MP_W-1:0]   m_signed;
    logic signed [MP_W-1:0]   m_frac;
    logic                     m_neg;
    logic [ANGLE_BITS-1:0]    m_d;
    logic [ANGLE_BITS-1:0]    m_h;
    logic signed [INC_W-1:0]  q_inc;
    logic [ANGLE_BITS-1:0]    n_hd;
    logic [ANGLE_BITS+23:0]   hd_wide;

    assign acc_in     = i_in_valid && !o_in_stall;
    assign start_work = acc_in && (i_in_word.elapsed_time != '0);
    assign mul_fin    = (r_state == ST_MUL_WAIT) && mul_rsp.done;
    assign div_fin    = (r_state == ST_DIV_WAIT) && div_rsp.done;
    assign cor_fin    = (r_state == ST_COR_WAIT) && cor_rsp.done;
    assign out_load   = (r_state == ST_OUT) && (!r_out_valid || !i_out_stall);
    assign is_div_op  = (r_op == OP_AL) || (r_op == OP_AR) ||
                        (r_op == OP_DL) || (r_op == OP_DR);

    // wheel speeds, forward step and wheel difference
    assign vl    = 25'(r_v) - 25'(r_t);
    assign vr    = 25'(r_v) + 25'(r_t);
    assign dsum  = 35'(r_dl) + 35'(r_dr);
    assign ds    = dsum[34:1];
    assign ddiff = 35'(r_dr) - 35'(r_dl);
    assign c_mag = r_c[CW-1] ? CW'(-r_c) : r_c;
    assign s_mag = r_s[CW-1] ? CW'(-r_s) : r_s;

    // operand select for the shared multiplier
    always_comb begin
        mul_req.start = (r_state == ST_MUL_GO);
        mul_req.a     = '0;
        mul_req.b     = '0;
        unique case (r_op)
            OP_T: begin
                mul_req.a = MA_W'(r_w);
                mul_req.b = MB_W'(r_hwb);
            end
            OP_QL: begin
                mul_req.a = MA_W'(vl);
                mul_req.b = MB_W'(r_iwr);
            end
            OP_QR: begin
                mul_req.a = MA_W'(vr);
                mul_req.b = MB_W'(r_iwr);
            end
            OP_AL: begin
                mul_req.a = MA_W'(r_ql);
                mul_req.b = MB_W'(r_dt);
            end
            OP_AR: begin
                mul_req.a = MA_W'(r_qr);
                mul_req.b = MB_W'(r_dt);
            end
            OP_WL: begin
                mul_req.a = MA_W'(r_ql);
                mul_req.b = MB_W'(r_wr);
            end
            OP_WR: begin
                mul_req.a = MA_W'(r_qr);
                mul_req.b = MB_W'(r_wr);
            end
            OP_DL, OP_DR: begin
                mul_req.a = MA_W'(r_wl);
                mul_req.b = MB_W'(r_dt);
            end
            OP_TH: begin
                mul_req.a = MA_W'(ddiff);
                mul_req.b = MB_W'(r_iwb);
            end
            OP_ANG: begin
                mul_req.a = MA_W'(r_dth);
                mul_req.b = INV_TWO_PI_Q32;
            end
            OP_X: begin
                mul_req.a = MA_W'(ds);
                mul_req.b = MB_W'(c_mag);
            end
            OP_Y: begin
                mul_req.a = MA_W'(ds);
                mul_req.b = MB_W'(s_mag);
            end
            default: begin
                mul_req.a = '0;
                mul_req.b = '0;
            end
        endcase
    end

    assign m_prod   = mul_rsp.prod;
    assign m_q      = m_prod >>> Q_SHIFT;
    assign m_neg    = (r_op == OP_X) ? r_c[CW-1] : r_s[CW-1];
    assign m_signed = m_neg ? -m_prod : m_prod;
    assign m_frac   = m_signed >>> FRAC_BITS;
    assign m_d      = m_prod[D_LSB +: ANGLE_BITS];
    assign m_h      = m_prod[H_LSB +: ANGLE_BITS];
    assign q_inc    = INC_W'(div_rsp.quot);

    assign div_req.start    = mul_fin && is_div_op;
    assign div_req.dividend = m_prod[DV_W-1:0];

    // CORDIC runs at heading plus half the turn, taken straight from the product
    assign cor_req.start = mul_fin && (r_op == OP_ANG);
    assign cor_req.phi   = r_hd + m_h;

    assign n_hd    = r_hd + r_d;
    assign hd_wide = {n_hd, 24'b0};

    ddo_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    ddo_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cor_req),
        .o_rsp   (cor_rsp)
    );

    // sequencer, configuration and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_op        <= OP_T;
            r_out_valid <= 1'b0;
            r_wr        <= 16'd6554;
            r_iwr       <= 24'd655360;
            r_hwb       <= 16'd21299;
            r_iwb       <= 24'd100824;
            r_x         <= '0;
            r_y         <= '0;
            r_hd        <= '0;
            r_left      <= '0;
            r_right     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_WHEEL_RADIUS:     r_wr  <= i_cfg_data[15:0];
                    REG_INV_WHEEL_RADIUS: r_iwr <= i_cfg_data;
                    REG_HALF_WHEEL_BASE:  r_hwb <= i_cfg_data[15:0];
                    REG_INV_WHEEL_BASE:   r_iwb <= i_cfg_data;
                    default:              r_wr  <= r_wr;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (start_work) begin
                        r_op    <= OP_T;
                        r_state <= ST_MUL_GO;
                    end
                end
                ST_MUL_GO: begin
                    r_state <= ST_MUL_WAIT;
                end
                ST_MUL_WAIT: begin
                    if (mul_fin) begin
                        if (r_op == OP_X) begin
                            r_x <= sat_add(r_x, m_frac[INC_W-1:0]);
                        end
                        if (r_op == OP_Y) begin
                            r_y <= sat_add(r_y, m_frac[INC_W-1:0]);
                        end
                        priority if (is_div_op) begin
                            r_state <= ST_DIV_WAIT;
                        end else if (r_op == OP_ANG) begin
                            r_state <= ST_COR_WAIT;
                        end else if (r_op == OP_Y) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_op    <= r_op + 1'b1;
                            r_state <= ST_MUL_GO;
                        end
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_fin) begin
                        if (r_op == OP_AL) begin
                            r_left <= sat_add(r_left, q_inc);
                        end
                        if (r_op == OP_AR) begin
                            r_right <= sat_add(r_right, q_inc);
                        end
                        r_op    <= r_op + 1'b1;
                        r_state <= ST_MUL_GO;
                    end
                end
                ST_COR_WAIT: begin
                    if (cor_fin) begin
                        r_op    <= OP_X;
                        r_state <= ST_MUL_GO;
                    end
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_hd    <= n_hd;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // per-tick intermediates
    always_ff @(posedge i_clk) begin
        if (start_work) begin
            r_v  <= i_in_word.linear_velocity;
            r_w  <= i_in_word.angular_velocity;
            r_dt <= i_in_word.elapsed_time;
        end
        if (mul_fin) begin
            if (r_op == OP_T) begin
                r_t <= m_q[23:0];
            end
            if (r_op == OP_QL) begin
                r_ql <= m_q[32:0];
            end
            if (r_op == OP_QR) begin
                r_qr <= m_q[32:0];
            end
            if ((r_op == OP_WL) || (r_op == OP_WR)) begin
                r_wl <= m_q[32:0];
            end
            if (r_op == OP_TH) begin
                r_dth <= m_q[42:0];
            end
            if (r_op == OP_ANG) begin
                r_d <= m_d;
            end
        end
        if (div_fin) begin
            if (r_op == OP_DL) begin
                r_dl <= div_rsp.quot;
            end
            if (r_op == OP_DR) begin
                r_dr <= div_rsp.quot;
            end
        end
        if (cor_fin) begin
            r_c <= cor_rsp.cos_val;
            r_s <= cor_rsp.sin_val;
        end
        if (out_load) begin
            r_out_word.pos_x             <= r_x;
            r_out_word.pos_y             <= r_y;
            r_out_word.heading           <= hd_wide[ANGLE_BITS+23 -: 16];
            r_out_word.left_wheel_angle  <= r_left;
            r_out_word.right_wheel_angle <= r_right;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

endmodule

### rtl/ddo_checker.sv
// Port-level checker for the odometry core, bound to the top level.
`include "diff_drive_odometry_core_assert.svh"

module ddo_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input ddo_pkg::t_in_word  i_in_word,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ddo_pkg::t_out_word o_out_word
);

    // a stalled result word stays up and unchanged
    `DDO_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `DDO_ASSERT_NEXT(a_out_stable, o_out_valid && i_out_stall, $stable(o_out_word))

    // a zero-time tick is dropped and leaves the core free
    `DDO_ASSERT_NEXT(a_skip_idle, i_in_valid && !o_in_stall && ~|i_in_word.elapsed_time, !o_in_stall)

    // a real tick keeps the core busy
    `DDO_ASSERT_NEXT(a_tick_busy, i_in_valid && !o_in_stall && |i_in_word.elapsed_time, o_in_stall)

    // a new result only comes out of a tick in progress
    `DDO_ASSERT_IMPLIES(a_result_from_work, $rose(o_out_valid), $past(o_in_stall))

endmodule

bind diff_drive_odometry_core ddo_checker u_ddo_checker (.*);
